// ----- design/modular_exponentiation_top_defines.svh -----
// Assertion macros for the modular exponentiation block.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MEXP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEXP_ASSERT(lbl, cond, msg)
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation block.
// Used by mexp_mulmod and modular_exponentiation_top; depends on nothing.
package mexp_pkg;

    localparam int WORD_W = 31;
    localparam int CNT_W = $clog2(WORD_W);
    localparam int EXPONENT_W = 32;
    localparam int EXP_BITS_MAX = 64;
    localparam int EXP_BITS_DEFAULT = 32;
    localparam logic [WORD_W-1:0] MODULUS_RESET = 31'd998244353;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULTIPLY,
        ST_FINISH
    } mexp_state_t;

endpackage

// ----- design/mexp_mulmod.sv -----
// Bit-serial interleaved shift-add modular multiplier, one bit of op_a per cycle.
// Depends on mexp_pkg and modular_exponentiation_top_defines.svh.
`include "modular_exponentiation_top_defines.svh"

module mexp_mulmod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mexp_pkg::WORD_W-1:0]    op_a,
    input  logic [mexp_pkg::WORD_W-1:0]    op_b,
    input  logic [mexp_pkg::WORD_W-1:0]    modulus,
    output mexp_pkg::mexp_mul_stat_t       stat,
    output logic [mexp_pkg::WORD_W-1:0]    product
);

    localparam int W = mexp_pkg::WORD_W;
    localparam int CW = mexp_pkg::CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W+1:0]  sum;
    logic [W+1:0]  diff1;
    logic [W+1:0]  diff2;
    logic [W+1:0]  mod1;
    logic [W+1:0]  mod2;

    // The running remainder stays below the modulus, so 2r + b is below three times it.
    assign mod1  = {2'b00, modulus};
    assign mod2  = {1'b0, modulus, 1'b0};
    assign sum   = {1'b0, r_reg, 1'b0} + (a_reg[W-1] ? {2'b00, b_reg} : '0);
    assign diff1 = sum - mod1;
    assign diff2 = sum - mod2;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (sum >= mod2)
            begin
                r_next = diff2[W-1:0];
            end
            else if (sum >= mod1)
            begin
                r_next = diff1[W-1:0];
            end
            else
            begin
                r_next = sum[W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = r_reg;

    `MEXP_ASSERT_NEXT(a_last_bit_done, busy_reg && cnt_reg == '0 && !start, done_reg, "Multiplier finished its last bit without signalling done.")
    `MEXP_ASSERT(a_done_not_busy, !(done_reg && busy_reg), "Multiplier signals done while still busy.")
    `MEXP_ASSERT(a_start_not_busy, !(start && busy_reg), "Multiplier launched while busy.")

endmodule

// ----- design/modular_exponentiation_top.sv -----
// Usage
// A transfer on the s_axis channel carries one base and one exponent; the block
// returns base to the power of exponent, reduced modulo the configured modulus, as
// one transfer on the m_axis channel. The modulus is written through cfg_we and
// cfg_wdata and resets to 998244353; the user must write it only while no item is
// in work, as the block does not enforce this. Each modular multiplication runs
// through a bit-serial multiplier that handles one bit of its operand per cycle,
// which sets the pace. An item needs one multiplication to reduce the base, one
// squaring for each of the low EXP_BITS exponent bits and one more for each of
// them that is set; the next item can be taken in the cycle the result appears.
// A modulus below two gives a result of zero without running the multiplier.
// One item is in work at a time; s_axis_tready is high while the engine is free,
// also while a finished result still waits in the output register.
// When the receiver stalls, the result is held on m_axis and the next item may be
// taken and worked on, but it waits at the end until the output register is free.
// Reset clears the engine and the output valid and restores the default modulus.
// Depends on mexp_pkg, mexp_mulmod and modular_exponentiation_top_defines.svh.
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,     // modulus
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // base [30:0], exponent [62:31], zero [63]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // power [30:0], zero [31]
);

    localparam int W = mexp_pkg::WORD_W;
    localparam int EW = mexp_pkg::EXPONENT_W;
    localparam int XW = mexp_pkg::EXP_BITS_MAX;
    localparam int ECW = $clog2(EXP_BITS + 1);
    localparam logic [W-1:0] ONE = W'(1);

    mexp_pkg::mexp_state_t    state_reg, state_next;
    mexp_pkg::mexp_mul_stat_t mul_stat;

    logic [W-1:0]        modulus_reg;
    logic                out_valid_reg, out_valid_next;
    logic                start_reg, start_next;
    logic [ECW-1:0]      cnt_reg, cnt_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        bred_reg, bred_next;
    logic [W-1:0]        opa_reg, opa_next;
    logic [W-1:0]        opb_reg, opb_next;
    logic [W-1:0]        res_reg, res_next;
    logic [W-1:0]        product;
    logic [XW-1:0]       exp_ext;
    logic                step_done;
    logic [W-1:0]        step_val;

    assign exp_ext = {{(XW - EW){1'b0}}, s_axis_tdata[W+EW-1:W]};

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .op_a    (opa_reg),
        .op_b    (opb_reg),
        .modulus (modulus_reg),
        .stat    (mul_stat),
        .product (product)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        start_next     = 1'b0;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        bred_next      = bred_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        res_next       = res_reg;
        step_done      = 1'b0;
        step_val       = product;
        s_axis_tready  = (state_reg == mexp_pkg::ST_IDLE);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    exp_next = exp_ext[EXP_BITS-1:0];
                    cnt_next = ECW'(EXP_BITS);
                    if (modulus_reg < W'(2))
                    begin
                        acc_next   = '0;
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        opa_next   = s_axis_tdata[W-1:0];
                        opb_next   = ONE;
                        start_next = 1'b1;
                        state_next = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mul_stat.done)
                begin
                    bred_next  = product;
                    acc_next   = ONE;
                    opa_next   = ONE;
                    opb_next   = ONE;
                    start_next = 1'b1;
                    state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_SQUARE:
            begin
                if (mul_stat.done)
                begin
                    acc_next = product;
                    if (exp_reg[EXP_BITS-1])
                    begin
                        opa_next   = product;
                        opb_next   = bred_reg;
                        start_next = 1'b1;
                        state_next = mexp_pkg::ST_MULTIPLY;
                    end
                    else
                    begin
                        step_done = 1'b1;
                    end
                end
            end
            mexp_pkg::ST_MULTIPLY:
            begin
                if (mul_stat.done)
                begin
                    acc_next  = product;
                    step_done = 1'b1;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    res_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase

        if (step_done)
        begin
            exp_next = exp_reg << 1;
            cnt_next = cnt_reg - ECW'(1);
            if (cnt_reg == ECW'(1))
            begin
                state_next = mexp_pkg::ST_FINISH;
            end
            else
            begin
                opa_next   = step_val;
                opb_next   = step_val;
                start_next = 1'b1;
                state_next = mexp_pkg::ST_SQUARE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            cnt_reg       <= '0;
            modulus_reg   <= mexp_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        bred_reg <= bred_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        res_reg  <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

    `MEXP_ASSERT_NEXT(a_start_busy, start_reg, mul_stat.busy, "Multiplier did not start after a launch.")
    `MEXP_ASSERT(a_ready_engine_free, !(s_axis_tready && (mul_stat.busy || start_reg)), "Input ready while the multiplier is in use.")
    `MEXP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Result changed or dropped during a stall.")

endmodule
